### src/btrd_pkg.sv
// ----------------------------------------------------------------------------
// btrd_pkg
// Shared types and constants for the radix digit packing core.
// ----------------------------------------------------------------------------
`default_nettype none

package btrd_pkg;

   // Default width of the value that is converted.
   localparam int VALUE_BITS_DEF = 31;

   // Quotient bits resolved by the divider in one cycle.
   localparam int STEP_BITS = 8;

   // Field widths.
   localparam int VALUE_W = 31;
   localparam int BASE_W  = 4;
   localparam int DIGIT_W = 4;
   localparam int PACK_W  = 31;

   // Legal radix range; codes outside it are clamped to the nearest end.
   localparam logic [BASE_W-1:0] RADIX_MIN = 4'd2;
   localparam logic [BASE_W-1:0] RADIX_MAX = 4'd10;

   // Largest packed value before saturation.
   localparam logic [PACK_W-1:0] PACK_LIMIT = 31'h7FFF_FFFF;

   // Input beat.
   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic [BASE_W-1:0]  base;
   } req_type;

   // Result beat.
   typedef struct packed {
      logic [PACK_W-1:0] packed_digits;
      logic              overflow;
   } rsp_type;

endpackage

`default_nettype wire

### src/btrd_div_step.sv
// ----------------------------------------------------------------------------
// btrd_div_step
// Restoring division step by a small radix: shifts STEP_BITS dividend bits
// through a narrow remainder and yields one quotient bit for each.
// ----------------------------------------------------------------------------
`default_nettype none

module btrd_div_step #(
   parameter int STEP_BITS = btrd_pkg::STEP_BITS
) (
   input  wire logic [btrd_pkg::BASE_W-1:0]  base,
   input  wire logic [btrd_pkg::DIGIT_W-1:0] rem_in,
   input  wire logic [STEP_BITS-1:0]         bits_in,
   output logic      [btrd_pkg::DIGIT_W-1:0] rem_out,
   output logic      [STEP_BITS-1:0]         quo_bits
);
   import btrd_pkg::*;

   // Each bit: append to the remainder, subtract the radix if it fits.
   always_comb begin
      logic [DIGIT_W:0] trial;
      logic [DIGIT_W-1:0] rem;
      rem      = rem_in;
      quo_bits = '0;
      for (int i = STEP_BITS - 1; i >= 0; i--) begin
         trial = {rem, bits_in[i]};
         if (trial >= {1'b0, base}) begin
            trial       = trial - {1'b0, base};
            quo_bits[i] = 1'b1;
         end
         rem = trial[DIGIT_W-1:0];
      end
      rem_out = rem;
   end

endmodule

`default_nettype wire

### src/binary_to_radix_digits_packed_core.sv
// ----------------------------------------------------------------------------
// binary_to_radix_digits_packed_core
// Converts a binary value to base-b digits by repeated division and packs
// the digits as decimal places, saturating at the signed 32-bit limit.
// ----------------------------------------------------------------------------
// Each base-b digit takes a pass of the shared 8-bit-per-cycle divider over
// the value; the digits are then packed, each read from the registered digit
// store and then accumulated, until the last digit or saturation, so that at
// most 11 digits are packed.
// One beat at a time: busy drops in the result strobe cycle; results never stall.
`default_nettype none

module binary_to_radix_digits_packed_core #(
   parameter int VALUE_BITS = btrd_pkg::VALUE_BITS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire btrd_pkg::req_type req_data,
   output logic                   rsp_strobe,
   output btrd_pkg::rsp_type      rsp_data
);
   import btrd_pkg::*;

   localparam int NSTEP = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
   localparam int PW    = NSTEP * STEP_BITS;
   localparam int SCW   = (NSTEP > 1) ? $clog2(NSTEP) : 1;
   localparam int AW    = $clog2(VALUE_BITS);
   localparam int CW    = $clog2(VALUE_BITS + 1);
   localparam int SW    = PACK_W + 4;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_DIV  = 4'b0010,
      ST_RD   = 4'b0100,
      ST_ACC  = 4'b1000
   } state_type;

   state_type          state_ff, state_in;
   logic [PW-1:0]      work_ff, work_in;
   logic [DIGIT_W-1:0] rem_ff, rem_in;
   logic [BASE_W-1:0]  base_ff, base_in;
   logic [SCW-1:0]     step_ff, step_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic [PACK_W-1:0]  acc_ff, acc_in;
   logic               strobe_ff, strobe_in;
   rsp_type            rsp_ff, rsp_in;
   logic [DIGIT_W-1:0] rd_data_ff;

   logic [DIGIT_W-1:0] dig_mem [VALUE_BITS];

   logic [DIGIT_W-1:0]   rem_next;
   logic [STEP_BITS-1:0] quo_bits;
   logic [CW-1:0]        cnt_dec;
   logic                 last_step;
   logic                 wr_en;
   logic [SW-1:0]        pack_sum;
   logic [BASE_W-1:0]    base_clamp;

   // Shared divider step.
   btrd_div_step #(
      .STEP_BITS (STEP_BITS)
   ) u_div_step (
      .base     (base_ff),
      .rem_in   (rem_ff),
      .bits_in  (work_ff[PW-1 -: STEP_BITS]),
      .rem_out  (rem_next),
      .quo_bits (quo_bits)
   );

   // Radix clamp into the legal range.
   always_comb begin
      if (req_data.base < RADIX_MIN) begin
         base_clamp = RADIX_MIN;
      end else if (req_data.base > RADIX_MAX) begin
         base_clamp = RADIX_MAX;
      end else begin
         base_clamp = req_data.base;
      end
   end

   assign cnt_dec   = cnt_ff - CW'(1);
   assign last_step = (step_ff == SCW'(NSTEP - 1));
   assign wr_en     = state_ff[1] && (work_ff != '0 || step_ff != '0) && last_step;
   // Decimal shift of the accumulator plus the next digit.
   assign pack_sum  = (SW'(acc_ff) << 3) + (SW'(acc_ff) << 1) + SW'(rd_data_ff);

   // Sequencer.
   always_comb begin
      state_in  = state_ff;
      work_in   = work_ff;
      rem_in    = rem_ff;
      base_in   = base_ff;
      step_in   = step_ff;
      cnt_in    = cnt_ff;
      acc_in    = acc_ff;
      strobe_in = 1'b0;
      rsp_in    = rsp_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               work_in  = PW'(VALUE_BITS'(req_data.value));
               base_in  = base_clamp;
               rem_in   = '0;
               step_in  = '0;
               cnt_in   = '0;
               acc_in   = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (step_ff == '0 && work_ff == '0) begin
               // Quotient exhausted: pack the stored digits, or finish on zero.
               if (cnt_ff == '0) begin
                  strobe_in = 1'b1;
                  rsp_in    = '{packed_digits: '0, overflow: 1'b0};
                  state_in  = ST_IDLE;
               end else begin
                  state_in = ST_RD;
               end
            end else begin
               work_in = PW'({work_ff, quo_bits});
               if (last_step) begin
                  rem_in  = '0;
                  step_in = '0;
                  cnt_in  = cnt_ff + CW'(1);
               end else begin
                  rem_in  = rem_next;
                  step_in = step_ff + SCW'(1);
               end
            end
         end
         ST_RD: begin
            cnt_in   = cnt_dec;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            if (pack_sum > SW'(PACK_LIMIT)) begin
               strobe_in = 1'b1;
               rsp_in    = '{packed_digits: PACK_LIMIT, overflow: 1'b1};
               state_in  = ST_IDLE;
            end else begin
               acc_in = pack_sum[PACK_W-1:0];
               if (cnt_ff == '0) begin
                  strobe_in = 1'b1;
                  rsp_in    = '{packed_digits: pack_sum[PACK_W-1:0], overflow: 1'b0};
                  state_in  = ST_IDLE;
               end else begin
                  state_in = ST_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      work_ff <= work_in;
      rem_ff  <= rem_in;
      base_ff <= base_in;
      step_ff <= step_in;
      cnt_ff  <= cnt_in;
      acc_ff  <= acc_in;
      rsp_ff  <= rsp_in;
   end

   // Digit store, least significant digit at the lowest address.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         dig_mem[cnt_ff[AW-1:0]] <= rem_next;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff[2]) begin
         rd_data_ff <= dig_mem[cnt_dec[AW-1:0]];
      end
   end

   assign busy       = !state_ff[0];
   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

`default_nettype wire

### test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the radix digit packing core. A queue of request
// beats, directed corner cases first and then random ones, feeds a clocked
// driver. A clocked monitor compares every result beat with the prediction
// made when the matching request was accepted.
// ----------------------------------------------------------------------------

module tb_top;

   import btrd_pkg::*;

   localparam int ITEM_COUNT  = 850;
   localparam int IDLE_PCT    = 32;
   localparam int CALM_FIRST  = 300;
   localparam int CALM_LAST   = 500;
   localparam int DRAIN_EVERY = 211;
   localparam int TAIL_CYCLES = 200;
   localparam int STALL_LIMIT = 5000;
   localparam logic [VALUE_W-1:0] VALUE_MAX = {VALUE_W{1'b1}};

   logic    clock    = 1'b0;
   logic    reset    = 1'b1;
   logic    start    = 1'b0;
   req_type req_data = '0;
   logic    busy;
   logic    rsp_strobe;
   rsp_type rsp_data;

   req_type pending_requests[$];
   rsp_type expected_digits[$];
   int      beats_sent     = 0;
   int      mismatch_count = 0;
   int      stall_cycles   = 0;

   binary_to_radix_digits_packed_core dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   always #1 clock = ~clock;

   // Divide repeatedly by the clamped radix, then pack the digits most
   // significant first as decimal places, saturating at the limit.
   function automatic rsp_type pack_radix_digits(req_type beat);
      longint unsigned quot;
      longint unsigned radix;
      longint unsigned acc;
      logic [DIGIT_W-1:0] digit_buf [64];
      int  count;
      int  idx;
      bit  saturated;
      rsp_type result;
      quot  = beat.value;
      radix = beat.base;
      if (radix < RADIX_MIN) radix = RADIX_MIN;
      if (radix > RADIX_MAX) radix = RADIX_MAX;
      count = 0;
      while (quot != 0 && count < 64) begin
         digit_buf[count] = DIGIT_W'(quot % radix);
         quot = quot / radix;
         count++;
      end
      acc = 0;
      saturated = 1'b0;
      idx = count - 1;
      while (idx >= 0 && !saturated) begin
         acc = acc * 10 + digit_buf[idx];
         if (acc > PACK_LIMIT) begin
            acc = PACK_LIMIT;
            saturated = 1'b1;
         end
         idx--;
      end
      result.packed_digits = acc[PACK_W-1:0];
      result.overflow      = saturated;
      return result;
   endfunction

   function automatic req_type make_beat(logic [VALUE_W-1:0] value, int base);
      req_type beat;
      beat.value = value;
      beat.base  = base[BASE_W-1:0];
      return beat;
   endfunction

   // Append one request beat to the pending queue.
   task automatic queue_request(req_type beat);
      pending_requests = {pending_requests, beat};
   endtask

   // Mostly legal radixes with a mix of value sizes; a share of radix codes
   // outside the legal range exercises the clamping.
   function automatic req_type make_random_beat();
      int base_pick;
      int value_pick;
      logic [VALUE_W-1:0] value;
      if ($urandom_range(0, 99) < 15) begin
         base_pick = $urandom_range(0, 6);
         if (base_pick >= 2) base_pick = base_pick + 9;
      end else begin
         base_pick = $urandom_range(2, 10);
      end
      value_pick = $urandom_range(0, 9);
      case (value_pick)
         4, 5: begin
            value = VALUE_W'($urandom_range(0, 1023));
         end
         6: begin
            case ($urandom_range(0, 2))
               0:       value = '0;
               1:       value = VALUE_W'(1);
               default: value = VALUE_MAX;
            endcase
         end
         7: begin
            value = VALUE_W'($urandom() >> $urandom_range(0, 31));
         end
         default: begin
            value = VALUE_W'($urandom());
         end
      endcase
      return make_beat(value, base_pick);
   endfunction

   task automatic report_mismatch(string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      mismatch_count++;
   endtask

   // Driver: retire the accepted beat, then hold, idle or offer the next one.
   always @(posedge clock) begin : drive_requests
      bit idle_now;
      bit drain_now;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            expected_digits = {expected_digits, pack_radix_digits(req_data)};
            pending_requests.delete(0);
            beats_sent++;
         end
         if (!(start && busy)) begin
            idle_now = ($urandom_range(0, 99) < IDLE_PCT) &&
                       !(beats_sent >= CALM_FIRST && beats_sent < CALM_LAST);
            drain_now = (beats_sent != 0) && (beats_sent % DRAIN_EVERY == 0) &&
                        (expected_digits.size() != 0);
            if (pending_requests.size() == 0 || idle_now || drain_now) begin
               start <= 1'b0;
            end else begin
               start    <= 1'b1;
               req_data <= pending_requests[0];
            end
         end
      end
   end

   // Monitor: every strobed result beat must match the oldest prediction.
   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (expected_digits.size() == 0) begin
            report_mismatch($sformatf("unexpected result digits=%0d overflow=%0b",
                                      rsp_data.packed_digits, rsp_data.overflow));
         end else begin
            want = expected_digits.pop_front();
            if (rsp_data.packed_digits !== want.packed_digits)
               report_mismatch($sformatf("packed_digits got %0d want %0d",
                                         rsp_data.packed_digits, want.packed_digits));
            if (rsp_data.overflow !== want.overflow)
               report_mismatch($sformatf("overflow got %0b want %0b",
                                         rsp_data.overflow, want.overflow));
         end
      end
   end

   // Watchdog: too long without any beat moving on either side ends the run.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin : stimulus
      int base_idx;
      // Zero input, unit input and the clamped radix codes.
      queue_request(make_beat('0, 2));
      queue_request(make_beat('0, 10));
      queue_request(make_beat('0, 0));
      queue_request(make_beat('0, 15));
      queue_request(make_beat(VALUE_W'(1), 2));
      queue_request(make_beat(VALUE_W'(1), 10));
      queue_request(make_beat(VALUE_W'(5), 1));
      queue_request(make_beat(VALUE_W'(5), 15));
      // Largest value in radixes 2, 3, 5 and 8 to 10 and in the clamped codes.
      for (base_idx = 0; base_idx <= 15; base_idx++)
         if (base_idx <= 3 || base_idx >= 8)
            queue_request(make_beat(VALUE_MAX, base_idx));
      queue_request(make_beat(VALUE_MAX, 5));
      // Saturation boundary: ten binary digits fit, eleven do not; then nine and eight in radix 9.
      queue_request(make_beat(VALUE_W'(1023), 2));
      queue_request(make_beat(VALUE_W'(1024), 2));
      queue_request(make_beat(VALUE_W'(9), 9));
      queue_request(make_beat(VALUE_W'(8), 9));
      while (pending_requests.size() < ITEM_COUNT)
         queue_request(make_random_beat());

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Let every request be accepted and every result arrive, then linger.
      while (pending_requests.size() != 0 || expected_digits.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
